// ===== hw/rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants of the tridiagonal solver
// Item structs, Q16.16 limits and saturation helpers.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int unsigned MaxRowsDefault = 64;
  localparam int unsigned DataW          = 32;
  localparam int unsigned IdxW           = 6;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = -32'sh7fff_ffff - 32'sh1;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } row_item_t;

  typedef struct packed {
    logic [5:0]         row_index;
    logic signed [31:0] solution;
    logic               failed;
    logic               end_of_run;
  } sol_item_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(SatMax))      r = SatMax;
    else if (v < 64'(SatMin)) r = SatMin;
    else                      r = v[31:0];
    return r;
  endfunction

  // Saturating 32-bit subtraction.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'(SatMax))      return SatMax;
    else if (d < 33'(SatMin)) return SatMin;
    else                      return d[31:0];
  endfunction

endpackage

// ===== hw/rtl/tridiagonal_system_solver.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_system_solver: Thomas-algorithm solver, Q16.16
// Forward elimination per row item, back substitution on the last row.
// ----------------------------------------------------------------------------
// Usage:
//   Row items enter on row_valid_i/row_ready_o, one row of the system each
//   (sub-, main- and super-diagonal, right-hand side, last-row flag).
//   Solution items leave on sol_valid_o/sol_ready_i, from the last index
//   down to index 0; end_of_run marks index 0. A zero diagonal or pivot
//   gives one item with failed set instead.
// Steps:
//   Row 0 is written to the stores directly. Every later row takes one
//   serial division (one quotient bit a cycle) for the multiplier plus two
//   multiplies and store reads/writes. Back substitution takes one store
//   read, one multiply and one serial division per emitted item.
//   One row is handled at a time; row_ready_o is low while a row or the
//   back substitution is in progress.
// Reset:
//   Clears the row counter, error flag and control; the stores are not
//   cleared, since only entries written in the current run are read.
// Stall:
//   A solution item waits in the output register; the back substitution
//   stops until it is taken.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver #(
  parameter int unsigned MAX_ROWS = tds_pkg::MaxRowsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               row_valid_i,
  output logic               row_ready_o,
  input  tds_pkg::row_item_t row_i,
  output logic               sol_valid_o,
  input  logic               sol_ready_i,
  output tds_pkg::sol_item_t sol_o
);
  import tds_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FDIV, S_FMUL, S_FWR,
    S_BRD, S_BMUL, S_BDIV, S_BOUT, S_ERR
  } state_e;

  state_e state_q;

  // Three stores, one synchronous read port and one write port each.
  logic signed [31:0] piv_mem [MAX_ROWS];
  logic signed [31:0] upr_mem [MAX_ROWS];
  logic signed [31:0] wrk_mem [MAX_ROWS];
  logic signed [31:0] piv_rd_q, upr_rd_q, wrk_rd_q;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_piv, wr_upr, wr_wrk;

  logic [AW:0]        cnt_q;      // rows received
  logic               zero_q;
  logic [AW-1:0]      idx_q;
  logic               last_q;
  row_item_t          row_q;
  logic signed [31:0] m_q, x_q, tp_q, tw_q;
  logic               have_x_q;
  sol_item_t          sol_q;
  logic               sol_v_q;

  logic               div_start;
  logic signed [31:0] div_num, div_den, div_q;
  logic               div_done;

  tds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_q)
  );

  logic signed [63:0] prod_a, prod_b;
  logic signed [31:0] mul_a, mul_b;
  assign prod_a = 64'(m_q) * 64'(upr_rd_q);
  assign prod_b = 64'(m_q) * 64'(wrk_rd_q);
  assign mul_a  = sat64(prod_a / 64'sd65536);
  assign mul_b  = sat64(prod_b / 64'sd65536);
  logic signed [63:0] prod_x;
  assign prod_x = 64'(upr_rd_q) * 64'(x_q);

  logic [AW-1:0] in_idx;
  logic          in_last;
  assign in_idx  = (cnt_q >= (AW+1)'(MAX_ROWS - 1)) ? AW'(MAX_ROWS - 1) : cnt_q[AW-1:0];
  assign in_last = row_i.last_row || (cnt_q >= (AW+1)'(MAX_ROWS - 1));

  // forward rows keep reading the previous entry; back substitution the current one
  assign rd_addr = (state_q == S_IDLE) ? (in_idx - AW'(1)) :
                   (state_q inside {S_FRD, S_FDIV, S_FMUL, S_FWR}) ? (idx_q - AW'(1)) :
                   idx_q;

  always_ff @(posedge clk_i) begin
    piv_rd_q <= piv_mem[rd_addr];
    upr_rd_q <= upr_mem[rd_addr];
    wrk_rd_q <= wrk_mem[rd_addr];
    if (we) begin
      piv_mem[wr_addr] <= wr_piv;
      upr_mem[wr_addr] <= wr_upr;
      wrk_mem[wr_addr] <= wr_wrk;
    end
  end

  logic accept_row;
  assign accept_row  = row_valid_i && row_ready_o;
  assign row_ready_o = (state_q == S_IDLE);

  always_comb begin
    we = 1'b0; wr_addr = idx_q;
    wr_piv = tp_q; wr_upr = row_q.super_diag; wr_wrk = tw_q;
    div_start = 1'b0; div_num = row_q.sub_diag; div_den = piv_rd_q;
    if (state_q == S_FRD) begin
      if (!zero_q && row_q.main_diag != '0 && idx_q == '0) begin
        we = 1'b1; wr_piv = row_q.main_diag; wr_wrk = row_q.rhs;
      end
      div_start = (idx_q != '0) && !zero_q && row_q.main_diag != '0;
    end else if (state_q == S_FWR) begin
      we = 1'b1;
    end else if (state_q == S_BMUL) begin
      div_start = 1'b1;
      div_den   = piv_rd_q;
      div_num   = have_x_q ? sat_sub(wrk_rd_q, sat64(prod_x / 64'sd65536)) : wrk_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      zero_q   <= 1'b0;
      sol_v_q  <= 1'b0;
      have_x_q <= 1'b0;
    end else begin
      if (sol_v_q && sol_ready_i && !((state_q == S_BOUT) || (state_q == S_ERR)))
        sol_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept_row) begin
          row_q   <= row_i;
          idx_q   <= in_idx;
          last_q  <= in_last;
          state_q <= S_FRD;
        end
        S_FRD: begin
          if (row_q.main_diag == '0) begin
            zero_q  <= 1'b1;
            state_q <= S_FWR;
          end else if (zero_q) begin
            state_q <= S_FWR;
          end else if (idx_q == '0) begin
            tp_q <= row_q.main_diag;
            tw_q <= row_q.rhs;
            state_q <= S_FMUL;
          end else begin
            state_q <= S_FDIV;
          end
        end
        S_FDIV: if (div_done) begin
          m_q     <= div_q;
          state_q <= S_FMUL;
        end
        S_FMUL: begin
          if (idx_q != '0) begin
            tp_q <= sat_sub(row_q.main_diag, mul_a);
            tw_q <= sat_sub(row_q.rhs, mul_b);
            if (sat_sub(row_q.main_diag, mul_a) == '0) zero_q <= 1'b1;
            state_q <= S_FWR;
          end else begin
            // row 0 already written
            if (!last_q) begin
              cnt_q   <= {1'b0, idx_q} + (AW+1)'(1);
              state_q <= S_IDLE;
            end else begin
              cnt_q    <= '0;
              have_x_q <= 1'b0;
              state_q  <= S_BRD;
            end
          end
        end
        S_FWR: begin
          if (!last_q) begin
            cnt_q   <= {1'b0, idx_q} + (AW+1)'(1);
            state_q <= S_IDLE;
          end else begin
            cnt_q <= '0;
            if (zero_q) begin
              state_q <= S_ERR;
            end else begin
              have_x_q <= 1'b0;
              state_q  <= S_BRD;
            end
          end
        end
        S_BRD: state_q <= S_BMUL;
        S_BMUL: state_q <= S_BDIV;
        S_BDIV: if (div_done) begin
          x_q     <= div_q;
          state_q <= S_BOUT;
        end
        S_BOUT: if (!sol_v_q || sol_ready_i) begin
          sol_v_q          <= 1'b1;
          sol_q.row_index  <= 6'(idx_q);
          sol_q.solution   <= x_q;
          sol_q.failed     <= 1'b0;
          sol_q.end_of_run <= (idx_q == '0);
          have_x_q         <= 1'b1;
          if (idx_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q - AW'(1);
            state_q <= S_BRD;
          end
        end
        S_ERR: if (!sol_v_q || sol_ready_i) begin
          sol_v_q          <= 1'b1;
          sol_q.row_index  <= '0;
          sol_q.solution   <= '0;
          sol_q.failed     <= 1'b1;
          sol_q.end_of_run <= 1'b1;
          zero_q           <= 1'b0;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sol_valid_o = sol_v_q;
  assign sol_o       = sol_q;

  // Rows are taken only when idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  // A stalled solution item holds.
  a_sol_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sol_valid_o && !sol_ready_i |=> sol_valid_o && $stable(sol_o))
    else $error("solution item changed under stall");
  // An error item always closes the run.
  a_err_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sol_valid_o && sol_o.failed |-> sol_o.end_of_run)
    else $error("failed item without end_of_run");

endmodule

// ===== hw/rtl/tds_div.sv =====
// ----------------------------------------------------------------------------
// tds_div: serial Q16.16 divider
// Restoring division of |a|*2^16 by |b|, one quotient bit a cycle, saturated.
// ----------------------------------------------------------------------------
module tds_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import tds_pkg::*;

  localparam int unsigned QW = 48;

  logic [QW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [QW:0]   trial;
  logic [QW-1:0] shl;
  logic [31:0]   an, bn;
  logic signed [QW:0] sres;

  always_comb begin
    an = num_i[31] ? 32'(-num_i) : 32'(num_i);
    bn = den_i[31] ? 32'(-den_i) : 32'(den_i);
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shl = '0; trial = '0;
    if (start_i) begin
      quo_d  = {an, 16'h0};
      rem_d  = '0;
      den_d  = bn;
      neg_d  = num_i[31] ^ den_i[31];
      cnt_d  = 6'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shl   = {rem_q[QW-2:0], quo_q[QW-1]};
      trial = {1'b0, shl} - {17'h0, den_q};
      if (!trial[QW]) begin
        rem_d = trial[QW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign sres   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign done_o = done_q;
  assign quot_o = sat64(64'(sres));

endmodule
